// ----- rtl/tfwm_pkg.sv -----
package tfwm_pkg;

  localparam int NUM_SLOTS_DEF      = 8;
  localparam int MAX_FILTER_LEN_DEF = 64;

  // Command codes of an input item
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_NAME  = 2'd2;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_HASH  = 8'h23;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] slot;
    logic [5:0] char_index;
    logic [7:0] byte_value;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] match_mask;
    logic       none_matched;
  } out_t;

  // Per-slot strobes for one processed item
  typedef struct packed {
    logic       wr;
    logic       clr;
    logic       step;
    logic       done;
    logic       last;
    logic [5:0] idx;
    logic [7:0] byte_val;
  } slot_ctl_t;

endpackage

// ----- rtl/tfwm_slot.sv -----
module tfwm_slot #(
  parameter int MAX_FILTER_LEN = tfwm_pkg::MAX_FILTER_LEN_DEF,
  parameter int CW             = $clog2(MAX_FILTER_LEN + 2)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tfwm_pkg::slot_ctl_t ctl,
  input  logic [CW-1:0]       cnt_r,
  input  logic [CW-1:0]       cnt_inc,
  input  logic [CW-1:0]       cnt_nxt,
  output logic                hit
);
  import tfwm_pkg::*;

  localparam int AW = (MAX_FILTER_LEN > 1) ? $clog2(MAX_FILTER_LEN) : 1;
  localparam int LW = $clog2(MAX_FILTER_LEN + 1);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_PLUS   = 2'd1,
    MODE_HASH   = 2'd2,
    MODE_FAIL   = 2'd3
  } mode_t;

  logic [7:0]    mem [MAX_FILTER_LEN];
  logic [7:0]    fpos_r;
  logic [7:0]    fcnt_r;

  mode_t         mode_r, mode_nxt, mode_a;
  logic [LW-1:0] pos_r, pos_nxt, pos_a;
  logic          exact_r, exact_nxt, exact_a;
  logic [LW-1:0] len_r, len_nxt;

  logic [7:0]    idx8;
  logic [8:0]    len9;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr_pos;
  logic [AW-1:0] raddr_cnt;
  logic [7:0]    c;

  assign c     = ctl.byte_val;
  assign idx8  = {2'b00, ctl.idx};
  assign len9  = {3'b000, ctl.idx} + 9'd1;
  assign waddr = idx8[AW-1:0];

  always_comb begin
    exact_a = exact_r && (cnt_r < CW'(len_r)) && (fcnt_r == c);
    mode_a  = mode_r;
    pos_a   = pos_r;
    if (mode_r == MODE_NORMAL || (mode_r == MODE_PLUS && c == CHAR_SLASH)) begin
      if (pos_r >= len_r) begin
        mode_a = MODE_FAIL;
      end else if (c == CHAR_SLASH && fpos_r != CHAR_SLASH) begin
        mode_a = MODE_FAIL;
      end else if (fpos_r == CHAR_PLUS) begin
        mode_a = MODE_PLUS;
        pos_a  = LW'(pos_r + 1'b1);
      end else if (fpos_r == CHAR_HASH) begin
        mode_a = MODE_HASH;
        pos_a  = LW'(pos_r + 1'b1);
      end else if (fpos_r != c) begin
        mode_a = MODE_FAIL;
      end else begin
        mode_a = MODE_NORMAL;
        pos_a  = LW'(pos_r + 1'b1);
      end
    end
  end

  assign hit = ctl.done && (len_r != '0) &&
               ((mode_a != MODE_FAIL && pos_a == len_r) ||
                (exact_a && cnt_inc == CW'(len_r)));

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    exact_nxt = exact_r;
    len_nxt   = len_r;
    if (ctl.done) begin
      mode_nxt  = MODE_NORMAL;
      pos_nxt   = '0;
      exact_nxt = 1'b1;
    end else if (ctl.step) begin
      mode_nxt  = mode_a;
      pos_nxt   = pos_a;
      exact_nxt = exact_a;
    end
    if (ctl.clr) begin
      len_nxt = '0;
    end else if (ctl.wr) begin
      len_nxt = ctl.last ? len9[LW-1:0] : '0;
    end
  end

  // Prefetch the filter bytes that the next item will compare against
  assign raddr_pos = rst_n ? pos_nxt[AW-1:0] : '0;
  assign raddr_cnt = rst_n ? cnt_nxt[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      pos_r   <= '0;
      exact_r <= 1'b1;
      len_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      exact_r <= exact_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[waddr] <= ctl.byte_val;
    end
    // Forward a same-cycle write so the prefetch sees the new byte
    fpos_r <= (ctl.wr && waddr == raddr_pos) ? ctl.byte_val : mem[raddr_pos];
    fcnt_r <= (ctl.wr && waddr == raddr_cnt) ? ctl.byte_val : mem[raddr_cnt];
  end

endmodule

// ----- rtl/topic_filter_wildcard_matcher.sv -----
// A result is registered in the output stage after the input stage has taken its last name byte.
// Throughput: one item per cycle, but a last name byte waits while an earlier result awaits out_ready;
// the per-slot filter memories prefetch the bytes the next item needs, so every slot advances on each name byte.
// Reset (rst_n low, synchronous): all slots empty, per-name tracking cleared,
// both channels empty; stored filter bytes are left as they are.
module topic_filter_wildcard_matcher #(
  parameter int NUM_SLOTS      = tfwm_pkg::NUM_SLOTS_DEF,
  parameter int MAX_FILTER_LEN = tfwm_pkg::MAX_FILTER_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tfwm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tfwm_pkg::out_t out_data
);
  import tfwm_pkg::*;

  localparam int CW = $clog2(MAX_FILTER_LEN + 2);

  logic                 s_valid_r;
  in_t                  s_item_r;
  logic                 out_valid_r;
  out_t                 out_data_r;
  logic [CW-1:0]        cnt_r, cnt_nxt, cnt_inc;

  logic                 emits;
  logic                 go;
  logic                 idx_ok;
  logic                 wr_any, clr_any, step, done;
  slot_ctl_t            ctl [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] hits;
  logic [7:0]           mask;

  assign emits    = (s_item_r.cmd == CMD_NAME) && s_item_r.last;
  // Hold the stage only when its result cannot be parked
  assign go       = s_valid_r && (!emits || !out_valid_r || out_ready);
  assign in_ready = rst_n && (!s_valid_r || go);

  assign idx_ok  = {3'b000, s_item_r.char_index} < 9'(MAX_FILTER_LEN);
  assign wr_any  = go && (s_item_r.cmd == CMD_WRITE) && idx_ok;
  assign clr_any = go && (s_item_r.cmd == CMD_CLEAR);
  assign step    = go && (s_item_r.cmd == CMD_NAME);
  assign done    = step && s_item_r.last;

  assign cnt_inc = (cnt_r <= CW'(MAX_FILTER_LEN)) ? CW'(cnt_r + 1'b1) : cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (!rst_n || done) begin
      cnt_nxt = '0;
    end else if (step) begin
      cnt_nxt = cnt_inc;
    end
  end

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    logic sel;
    assign sel = ({3'b000, s_item_r.slot} == 6'(i));

    always_comb begin
      ctl[i].wr       = wr_any && sel;
      ctl[i].clr      = clr_any && sel;
      ctl[i].step     = step;
      ctl[i].done     = done;
      ctl[i].last     = s_item_r.last;
      ctl[i].idx      = s_item_r.char_index;
      ctl[i].byte_val = s_item_r.byte_value;
    end

    tfwm_slot #(
      .MAX_FILTER_LEN(MAX_FILTER_LEN),
      .CW            (CW)
    ) u_slot (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl[i]),
      .cnt_r  (cnt_r),
      .cnt_inc(cnt_inc),
      .cnt_nxt(cnt_nxt),
      .hit    (hits[i])
    );
  end

  for (genvar i = 0; i < 8; i++) begin : g_mask
    if (i < NUM_SLOTS) begin : g_on
      assign mask[i] = hits[i];
    end else begin : g_off
      assign mask[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_valid && in_ready) begin
        s_valid_r <= 1'b1;
      end else if (go) begin
        s_valid_r <= 1'b0;
      end
      if (go && emits) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item_r <= in_data;
    end
    if (go && emits) begin
      out_data_r.match_mask   <= mask;
      out_data_r.none_matched <= (mask == 8'd0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
